// File: hw/rtl/lav_pkg.sv
package lav_pkg;

   localparam int FIX_W = 32;
   localparam int WIDE_W = 64;

   // Signed Q16.16 input values and Q2.30 unit vector components.
   typedef logic signed [FIX_W-1:0] fix_type;
   // Cross products before normalization.
   typedef logic signed [WIDE_W-1:0] wide_type;

   // Information that rides along with a transaction through every unit.
   typedef struct packed {
      fix_type [2:0] eye;
      logic          degen;
   } side_type;

   // Side information plus a second vector that a later stage needs.
   typedef struct packed {
      side_type      base;
      fix_type [2:0] aux;
   } nside_type;

endpackage

// File: hw/rtl/lav_norm.sv
module lav_norm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  lav_pkg::wide_type [2:0]   in_vec,
   input  lav_pkg::nside_type        in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output lav_pkg::fix_type [2:0]    out_vec,
   output logic                      out_zero,
   output lav_pkg::nside_type        out_side
);

   localparam int NPREP = 5;
   localparam int NSQ = 16;
   localparam int NDV = 16;
   localparam int NST = NPREP + NSQ + NDV + 1;
   localparam int SQ0 = NPREP;
   localparam int DV0 = NPREP + NSQ;
   localparam int LAST = NST - 1;

   typedef struct packed {
      logic [2:0][29:0]   nm;
      logic [2:0]         neg;
      logic               zero;
      lav_pkg::nside_type side;
   } core_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [30:0] root;
   } sqs_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [30:0] q;
   } dvs_type;

   // One bit of the square root: t = (2*root + 2^j) * 2^j.
   function automatic sqs_type sqrt_step(input sqs_type a, input int j);
      logic [63:0] t;
      sqs_type     r;
      t = ({33'd0, a.root} << (j + 1)) + (64'd1 << (2 * j));
      r = a;
      if (a.rem >= t) begin
         r.rem = a.rem - t;
         r.root = a.root | (31'd1 << j);
      end
      return r;
   endfunction

   // One bit of restoring division.
   function automatic dvs_type div_step(input dvs_type a, input logic [30:0] s, input int j);
      logic [63:0] t;
      dvs_type     r;
      t = {33'd0, s} << j;
      r = a;
      if (a.rem >= t) begin
         r.rem = a.rem - t;
         r.q = a.q | (31'd1 << j);
      end
      return r;
   endfunction

   logic [NST-1:0]          v_ff;
   logic [NST-1:0]          v_in;
   logic [NST-1:0]          en;

   logic [2:0][62:0]        p0_mag_ff, p0_mag_in;
   logic [62:0]             p0_top_ff, p0_top_in;
   logic [2:0]              p0_neg_ff, p0_neg_in;
   lav_pkg::nside_type      p0_side_ff;

   logic [2:0][62:0]        p1_mag_ff;
   logic [5:0]              p1_pos_ff, p1_pos_in;
   logic                    p1_zero_ff;
   logic [2:0]              p1_neg_ff;
   lav_pkg::nside_type      p1_side_ff;

   core_type                core_ff [2:LAST-1];
   core_type                core2_in;
   logic [2:0][59:0]        sq_ff, sq_in;
   logic [61:0]             sum_ff, sum_in;

   sqs_type                 sq_st_ff [NSQ];
   sqs_type                 sq_st_in [NSQ];
   dvs_type                 dv_ff [NDV][3];
   dvs_type                 dv_in [NDV][3];
   logic [30:0]             dvs_ff [NDV];
   logic [30:0]             dvs_in [NDV];

   lav_pkg::fix_type [2:0]  out_vec_ff, out_vec_in;
   logic                    out_zero_ff;
   lav_pkg::nside_type      out_side_ff;

   // A stage takes new data when it is empty or when the stage after it moves.
   always_comb begin
      en[LAST] = !v_ff[LAST] || out_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = in_valid;
      for (int i = 1; i < NST; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   assign in_ready = en[0];
   assign out_valid = v_ff[LAST];
   assign out_vec = out_vec_ff;
   assign out_zero = out_zero_ff;
   assign out_side = out_side_ff;

   // Magnitudes and the largest of them.
   always_comb begin
      logic [63:0] m64;
      for (int i = 0; i < 3; i++) begin
         m64 = in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
         p0_mag_in[i] = m64[62:0];
         p0_neg_in[i] = in_vec[i][63];
      end
      p0_top_in = p0_mag_in[0];
      if (p0_mag_in[1] > p0_top_in) begin
         p0_top_in = p0_mag_in[1];
      end
      if (p0_mag_in[2] > p0_top_in) begin
         p0_top_in = p0_mag_in[2];
      end
   end

   always_comb begin
      p1_pos_in = '0;
      for (int b = 0; b < 63; b++) begin
         if (p0_top_ff[b]) begin
            p1_pos_in = 6'(b);
         end
      end
   end

   // Bring the largest magnitude into [2^29, 2^30); right shifts truncate.
   always_comb begin
      core2_in.neg = p1_neg_ff;
      core2_in.zero = p1_zero_ff;
      core2_in.side = p1_side_ff;
      for (int i = 0; i < 3; i++) begin
         if (p1_pos_ff > 6'd29) begin
            core2_in.nm[i] = 30'(p1_mag_ff[i] >> (p1_pos_ff - 6'd29));
         end else begin
            core2_in.nm[i] = 30'(p1_mag_ff[i] << (6'd29 - p1_pos_ff));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = core_ff[2].nm[i] * core_ff[2].nm[i];
      end
      sum_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   end

   // Square root, two result bits per stage (one in the last).
   always_comb begin
      sqs_type st;
      for (int k = 0; k < NSQ; k++) begin
         if (k == 0) begin
            st.rem = {2'b00, sum_ff};
            st.root = '0;
         end else begin
            st = sq_st_ff[k-1];
         end
         st = sqrt_step(st, 30 - 2 * k);
         if (29 - 2 * k >= 0) begin
            st = sqrt_step(st, 29 - 2 * k);
         end
         sq_st_in[k] = st;
      end
   end

   // Three quotients (mag << 30) / root, two bits per stage (one in the last).
   always_comb begin
      dvs_type     st;
      logic [30:0] s;
      for (int k = 0; k < NDV; k++) begin
         if (k == 0) begin
            s = sq_st_ff[NSQ-1].root;
         end else begin
            s = dvs_ff[k-1];
         end
         dvs_in[k] = s;
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               st.rem = {4'd0, core_ff[DV0-1].nm[i], 30'd0};
               st.q = '0;
            end else begin
               st = dv_ff[k-1][i];
            end
            st = div_step(st, s, 30 - 2 * k);
            if (29 - 2 * k >= 0) begin
               st = div_step(st, s, 29 - 2 * k);
            end
            dv_in[k][i] = st;
         end
      end
   end

   always_comb begin
      logic [31:0] qv;
      for (int i = 0; i < 3; i++) begin
         qv = {1'b0, dv_ff[NDV-1][i].q};
         if (core_ff[LAST-1].zero) begin
            out_vec_in[i] = '0;
         end else if (core_ff[LAST-1].neg[i]) begin
            out_vec_in[i] = 32'd0 - qv;
         end else begin
            out_vec_in[i] = qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p0_mag_ff <= p0_mag_in;
         p0_top_ff <= p0_top_in;
         p0_neg_ff <= p0_neg_in;
         p0_side_ff <= in_side;
      end
      if (en[1]) begin
         p1_mag_ff <= p0_mag_ff;
         p1_pos_ff <= p1_pos_in;
         p1_zero_ff <= (p0_top_ff == '0);
         p1_neg_ff <= p0_neg_ff;
         p1_side_ff <= p0_side_ff;
      end
      if (en[2]) begin
         core_ff[2] <= core2_in;
      end
      for (int i = 3; i <= LAST - 1; i++) begin
         if (en[i]) begin
            core_ff[i] <= core_ff[i-1];
         end
      end
      if (en[3]) begin
         sq_ff <= sq_in;
      end
      if (en[4]) begin
         sum_ff <= sum_in;
      end
      for (int k = 0; k < NSQ; k++) begin
         if (en[SQ0+k]) begin
            sq_st_ff[k] <= sq_st_in[k];
         end
      end
      for (int k = 0; k < NDV; k++) begin
         if (en[DV0+k]) begin
            dv_ff[k] <= dv_in[k];
            dvs_ff[k] <= dvs_in[k];
         end
      end
      if (en[LAST]) begin
         out_vec_ff <= out_vec_in;
         out_zero_ff <= core_ff[LAST-1].zero;
         out_side_ff <= core_ff[LAST-1].side;
      end
   end

endmodule

// File: hw/rtl/lav_cross.sv
module lav_cross (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  lav_pkg::fix_type [2:0]   in_a,
   input  lav_pkg::fix_type [2:0]   in_b,
   input  lav_pkg::side_type        in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output lav_pkg::wide_type [2:0]  out_c,
   output lav_pkg::fix_type [2:0]   out_a,
   output lav_pkg::fix_type [2:0]   out_b,
   output lav_pkg::side_type        out_side
);

   logic [1:0]              v_ff;
   logic [1:0]              en;

   logic signed [63:0]      prod_ff [6];
   logic signed [63:0]      prod_in [6];
   lav_pkg::fix_type [2:0]  a0_ff, b0_ff;
   lav_pkg::side_type       side0_ff;

   lav_pkg::wide_type [2:0] c_ff, c_in;
   lav_pkg::fix_type [2:0]  a1_ff, b1_ff;
   lav_pkg::side_type       side1_ff;

   assign en[1] = !v_ff[1] || out_ready;
   assign en[0] = !v_ff[0] || en[1];
   assign in_ready = en[0];
   assign out_valid = v_ff[1];
   assign out_c = c_ff;
   assign out_a = a1_ff;
   assign out_b = b1_ff;
   assign out_side = side1_ff;

   always_comb begin
      prod_in[0] = $signed(in_a[1]) * $signed(in_b[2]);
      prod_in[1] = $signed(in_a[2]) * $signed(in_b[1]);
      prod_in[2] = $signed(in_a[2]) * $signed(in_b[0]);
      prod_in[3] = $signed(in_a[0]) * $signed(in_b[2]);
      prod_in[4] = $signed(in_a[0]) * $signed(in_b[1]);
      prod_in[5] = $signed(in_a[1]) * $signed(in_b[0]);
      c_in[0] = prod_ff[0] - prod_ff[1];
      c_in[1] = prod_ff[2] - prod_ff[3];
      c_in[2] = prod_ff[4] - prod_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         a0_ff <= in_a;
         b0_ff <= in_b;
         side0_ff <= in_side;
      end
      if (en[1]) begin
         c_ff <= c_in;
         a1_ff <= a0_ff;
         b1_ff <= b0_ff;
         side1_ff <= side0_ff;
      end
   end

endmodule

// File: hw/rtl/lav_out.sv
module lav_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  lav_pkg::wide_type [2:0]  in_c,
   input  lav_pkg::fix_type [2:0]   in_r,
   input  lav_pkg::fix_type [2:0]   in_f,
   input  lav_pkg::side_type        in_side,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [135:0]             rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   localparam int NST = 4;
   localparam int LAST = NST - 1;
   localparam logic [1:0] COL_LAST = 2'd3;
   localparam lav_pkg::fix_type FIX_ONE = 32'h0001_0000;

   // Round half away from zero by 2^k, then saturate to 32 bits.
   function automatic lav_pkg::fix_type round_sat(input logic signed [65:0] v, input int k);
      logic [65:0]        m;
      logic signed [66:0] sv;
      m = v[65] ? 66'(-v) : 66'(v);
      m = m + (66'd1 << (k - 1));
      m = m >> k;
      sv = v[65] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (sv > 67'sd2147483647) begin
         round_sat = 32'h7FFF_FFFF;
      end else if (sv < -67'sd2147483648) begin
         round_sat = 32'h8000_0000;
      end else begin
         round_sat = sv[31:0];
      end
   endfunction

   logic [NST-1:0]          v_ff;
   logic [NST-1:0]          en;
   logic [1:0]              col_ff;

   lav_pkg::fix_type [2:0]  u0_ff, u0_in, r0_ff, f0_ff;
   lav_pkg::side_type       side0_ff;

   logic signed [63:0]      pr_ff [3], pu_ff [3], pf_ff [3];
   logic signed [63:0]      pr_in [3], pu_in [3], pf_in [3];
   lav_pkg::fix_type [2:0]  rq1_ff, uq1_ff, nfq1_ff, rq1_in, uq1_in, nfq1_in;
   logic                    degen1_ff;

   logic signed [65:0]      tr_ff, tu_ff, tf_ff, tr_in, tu_in, tf_in;
   lav_pkg::fix_type [2:0]  rq2_ff, uq2_ff, nfq2_ff;
   logic                    degen2_ff;

   lav_pkg::fix_type [2:0]  row_ff [4];
   lav_pkg::fix_type [2:0]  row_in [4];
   logic                    degen3_ff;

   // The output stage frees up once its fourth column is taken.
   always_comb begin
      en[LAST] = !v_ff[LAST] || (rsp_tready && (col_ff == COL_LAST));
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u0_in[i] = round_sat(66'($signed(in_c[i])), 30);
         pr_in[i] = $signed(r0_ff[i]) * $signed(side0_ff.eye[i]);
         pu_in[i] = $signed(u0_ff[i]) * $signed(side0_ff.eye[i]);
         pf_in[i] = $signed(f0_ff[i]) * $signed(side0_ff.eye[i]);
         rq1_in[i] = round_sat(66'($signed(r0_ff[i])), 14);
         uq1_in[i] = round_sat(66'($signed(u0_ff[i])), 14);
         nfq1_in[i] = round_sat(-66'($signed(f0_ff[i])), 14);
      end
      tr_in = 66'(pr_ff[0]) + 66'(pr_ff[1]) + 66'(pr_ff[2]);
      tu_in = 66'(pu_ff[0]) + 66'(pu_ff[1]) + 66'(pu_ff[2]);
      tf_in = 66'(pf_ff[0]) + 66'(pf_ff[1]) + 66'(pf_ff[2]);
   end

   // Columns 0 to 2 carry the rotation, column 3 the translation.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_in[k][0] = rq2_ff[k];
         row_in[k][1] = uq2_ff[k];
         row_in[k][2] = nfq2_ff[k];
      end
      row_in[3][0] = round_sat(-tr_ff, 30);
      row_in[3][1] = round_sat(-tu_ff, 30);
      row_in[3][2] = round_sat(tf_ff, 30);
      if (degen2_ff) begin
         for (int k = 0; k < 4; k++) begin
            row_in[k] = '0;
         end
      end
   end

   always_comb begin
      rsp_tvalid = v_ff[LAST];
      rsp_tlast = (col_ff == COL_LAST);
      rsp_tuser = degen3_ff;
      rsp_tdata = '0;
      rsp_tdata[1:0] = col_ff;
      rsp_tdata[33:2] = row_ff[col_ff][0];
      rsp_tdata[65:34] = row_ff[col_ff][1];
      rsp_tdata[97:66] = row_ff[col_ff][2];
      rsp_tdata[129:98] = (col_ff == COL_LAST) ? FIX_ONE : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         col_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (en[LAST]) begin
            col_ff <= '0;
         end else if (rsp_tready) begin
            col_ff <= col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u0_ff <= u0_in;
         r0_ff <= in_r;
         f0_ff <= in_f;
         side0_ff <= in_side;
      end
      if (en[1]) begin
         pr_ff <= pr_in;
         pu_ff <= pu_in;
         pf_ff <= pf_in;
         rq1_ff <= rq1_in;
         uq1_ff <= uq1_in;
         nfq1_ff <= nfq1_in;
         degen1_ff <= side0_ff.degen;
      end
      if (en[2]) begin
         tr_ff <= tr_in;
         tu_ff <= tu_in;
         tf_ff <= tf_in;
         rq2_ff <= rq1_ff;
         uq2_ff <= uq1_ff;
         nfq2_ff <= nfq1_ff;
         degen2_ff <= degen1_ff;
      end
      if (en[LAST]) begin
         row_ff <= row_in;
         degen3_ff <= degen2_ff;
      end
   end

endmodule

// File: hw/rtl/look_at_view_matrix.sv
// Look-at view matrix in signed Q16.16 fixed point.
// The req channel carries one transaction per camera: eye point, target point
// and approximate up vector. For each one the rsp channel returns four
// transactions, columns 0 to 3 of the column-major view matrix; tlast marks
// column 3 and tuser is the degenerate flag, set on all four when the forward
// or right vector has zero length (rows 0 to 2 are then zero).
// Column 0 appears once the request has passed through every stage; the
// other columns follow one per cycle while rsp_tready is high. The path is two
// normalization units of 38 stages each (square root and divides at two bits per
// stage, one bit in the last), two cross-product units of 2 stages and a 4-stage
// output unit. Its last stage takes a new matrix only once all four columns of
// the one before are taken; a request may enter in any cycle while stages are free.
// Reset empties every stage; no transaction is in flight afterwards.
// When the receiver stalls, the current column holds on rsp_tdata and the
// stages behind it keep filling until they are all occupied, after which
// req_tready drops. Nothing is lost or repeated.
module look_at_view_matrix (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
   input  logic [287:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // column_index, entry_row0, entry_row1, entry_row2, entry_row3, zero pad
   output logic [135:0]  rsp_tdata,
   output logic          rsp_tlast,
   // degenerate
   output logic          rsp_tuser
);

   lav_pkg::fix_type [2:0]  eye, tgt, upv;
   lav_pkg::wide_type [2:0] dvec;
   lav_pkg::nside_type      n0_side_in, n0_side, n1_side_in, n1_side;
   lav_pkg::side_type       c1_side_in, c1_side, c2_side_in, c2_side;
   lav_pkg::fix_type [2:0]  n0_vec, n1_vec, c1_a, c1_b, c2_a, c2_b;
   lav_pkg::wide_type [2:0] c1_c, c2_c;
   logic                    n0_zero, n1_zero;
   logic                    n0_valid, n0_ready, c1_valid, c1_ready;
   logic                    n1_valid, n1_ready, c2_valid, c2_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye[i] = req_tdata[32*i +: 32];
         tgt[i] = req_tdata[96 + 32*i +: 32];
         upv[i] = req_tdata[192 + 32*i +: 32];
         dvec[i] = 64'($signed(tgt[i])) - 64'($signed(eye[i]));
      end
      n0_side_in.base.eye = eye;
      n0_side_in.base.degen = 1'b0;
      n0_side_in.aux = upv;
      c1_side_in.eye = n0_side.base.eye;
      c1_side_in.degen = n0_zero;
      n1_side_in.base = c1_side;
      n1_side_in.aux = c1_a;
      c2_side_in.eye = n1_side.base.eye;
      c2_side_in.degen = n1_side.base.degen | n1_zero;
   end

   // Forward vector.
   lav_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vec    (dvec),
      .in_side   (n0_side_in),
      .out_valid (n0_valid),
      .out_ready (n0_ready),
      .out_vec   (n0_vec),
      .out_zero  (n0_zero),
      .out_side  (n0_side)
   );

   lav_cross u_cross_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n0_valid),
      .in_ready  (n0_ready),
      .in_a      (n0_vec),
      .in_b      (n0_side.aux),
      .in_side   (c1_side_in),
      .out_valid (c1_valid),
      .out_ready (c1_ready),
      .out_c     (c1_c),
      .out_a     (c1_a),
      .out_b     (c1_b),
      .out_side  (c1_side)
   );

   // Right vector.
   lav_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_ready  (c1_ready),
      .in_vec    (c1_c),
      .in_side   (n1_side_in),
      .out_valid (n1_valid),
      .out_ready (n1_ready),
      .out_vec   (n1_vec),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   lav_cross u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_valid),
      .in_ready  (n1_ready),
      .in_a      (n1_vec),
      .in_b      (n1_side.aux),
      .in_side   (c2_side_in),
      .out_valid (c2_valid),
      .out_ready (c2_ready),
      .out_c     (c2_c),
      .out_a     (c2_a),
      .out_b     (c2_b),
      .out_side  (c2_side)
   );

   lav_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c2_valid),
      .in_ready   (c2_ready),
      .in_c       (c2_c),
      .in_r       (c2_a),
      .in_f       (c2_b),
      .in_side    (c2_side),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/sv/look_at_view_matrix_checker.sv
module look_at_view_matrix_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [287:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [135:0]  rsp_tdata,
   input  logic          rsp_tlast,
   input  logic          rsp_tuser,
   output int            fail_count,
   output int            pending_columns,
   output int            matrices_seen,
   output int            degenerate_seen
);

   typedef struct packed {
      logic [1:0]  column;
      logic [31:0] row0;
      logic [31:0] row1;
      logic [31:0] row2;
      logic [31:0] row3;
      logic        last;
      logic        degen;
   } column_type;

   column_type expected_columns[$];

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int k);
      logic [63:0] m;
      m = (magnitude(v) + (64'd1 << (k - 1))) >> k;
      return v < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [31:0] to_fix(input logic signed [63:0] v, input int k);
      logic signed [63:0] t;
      t = round_shift(v, k);
      if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
      if (t < -64'sh80000000) t = -64'sh80000000;
      return t[31:0];
   endfunction

   // Returns 0 for a zero vector; otherwise writes a Q2.30 unit vector.
   function automatic bit normalize(input logic signed [63:0] v[3],
                                    output logic signed [63:0] unit[3]);
      logic [63:0] m[3];
      logic [63:0] top;
      logic [63:0] sum;
      logic [63:0] root;
      logic [63:0] q;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > top) top = m[i];
         unit[i] = 0;
      end
      if (top == 0) return 0;
      while (top >= (64'd1 << 30)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 29)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] << 30) / root;
         unit[i] = v[i] < 0 ? -$signed(q) : $signed(q);
      end
      return 1;
   endfunction

   task automatic predict_view_matrix(input logic [287:0] data);
      logic signed [63:0] eye[3], tgt[3], up[3], dir[3], fwd[3], rc[3], rgt[3], tru[3];
      logic signed [63:0] tr, tu, tf;
      logic [31:0] cols[4][4];
      bit degen;
      column_type c;
      for (int i = 0; i < 3; i++) begin
         eye[i] = $signed(data[32*i +: 32]);
         tgt[i] = $signed(data[32*(3+i) +: 32]);
         up[i] = $signed(data[32*(6+i) +: 32]);
         dir[i] = tgt[i] - eye[i];
      end
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 4; i++) cols[k][i] = 0;
      cols[3][3] = 32'h00010000;
      degen = !normalize(dir, fwd);
      if (!degen) begin
         rc[0] = fwd[1] * up[2] - fwd[2] * up[1];
         rc[1] = fwd[2] * up[0] - fwd[0] * up[2];
         rc[2] = fwd[0] * up[1] - fwd[1] * up[0];
         degen = !normalize(rc, rgt);
      end
      if (!degen) begin
         tr = 0;
         tu = 0;
         tf = 0;
         tru[0] = round_shift(rgt[1] * fwd[2] - rgt[2] * fwd[1], 30);
         tru[1] = round_shift(rgt[2] * fwd[0] - rgt[0] * fwd[2], 30);
         tru[2] = round_shift(rgt[0] * fwd[1] - rgt[1] * fwd[0], 30);
         for (int k = 0; k < 3; k++) begin
            cols[k][0] = to_fix(rgt[k], 14);
            cols[k][1] = to_fix(tru[k], 14);
            cols[k][2] = to_fix(-fwd[k], 14);
            tr += rgt[k] * eye[k];
            tu += tru[k] * eye[k];
            tf += fwd[k] * eye[k];
         end
         cols[3][0] = to_fix(-tr, 30);
         cols[3][1] = to_fix(-tu, 30);
         cols[3][2] = to_fix(tf, 30);
      end
      for (int k = 0; k < 4; k++) begin
         c.column = k[1:0];
         c.row0 = cols[k][0];
         c.row1 = cols[k][1];
         c.row2 = cols[k][2];
         c.row3 = cols[k][3];
         c.last = (k == 3);
         c.degen = degen;
         expected_columns.push_back(c);
      end
   endtask

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      column_type want;
      if (reset) begin
         expected_columns.delete();
      end else begin
         if (req_tvalid && req_tready) predict_view_matrix(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_columns.size() == 0) begin
               report("unexpected column transaction", 0, rsp_tdata[31:0]);
            end else begin
               want = expected_columns.pop_front();
               if (rsp_tdata[1:0] != want.column) report("column_index", want.column, rsp_tdata[1:0]);
               if (rsp_tdata[33:2] != want.row0) report("entry_row0", want.row0, rsp_tdata[33:2]);
               if (rsp_tdata[65:34] != want.row1) report("entry_row1", want.row1, rsp_tdata[65:34]);
               if (rsp_tdata[97:66] != want.row2) report("entry_row2", want.row2, rsp_tdata[97:66]);
               if (rsp_tdata[129:98] != want.row3) report("entry_row3", want.row3, rsp_tdata[129:98]);
               if (rsp_tdata[135:130] != 0) report("tdata padding", 0, rsp_tdata[135:130]);
               if (rsp_tlast != want.last) report("last_column", want.last, rsp_tlast);
               if (rsp_tuser != want.degen) report("degenerate", want.degen, rsp_tuser);
               if (want.last) matrices_seen++;
               if (want.last && want.degen) degenerate_seen++;
            end
         end
      end
      pending_columns = expected_columns.size();
   end

   initial begin
      fail_count = 0;
      pending_columns = 0;
      matrices_seen = 0;
      degenerate_seen = 0;
   end
endmodule

// File: tb/sv/tb_look_at_view_matrix.sv
module tb_look_at_view_matrix;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LATENCY = 84;
   localparam int FIRST_CAMERAS = 30;
   localparam int STALL_CAMERAS = 100;
   localparam int LATE_CAMERAS = 15;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [287:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [135:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          rsp_tuser;

   int fail_count, pending_columns, matrices_seen, degenerate_seen;
   int sender_idle_pct = 36;
   int receiver_idle_pct = 47;
   int cycle_count = 0;
   int hold_off = 0;
   int cameras_sent = 0;

   always #5 clock = ~clock;

   look_at_view_matrix dut (.*);

   look_at_view_matrix_checker monitor (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic logic [31:0] rand_fix();
      case ($urandom_range(5))
         0: return 32'h80000000 | $urandom_range(3);
         1: return 32'h7FFFFFFF - $urandom_range(3);
         2: return $urandom_range(8) - 4;
         3: return $urandom;
         default: return $signed($urandom_range(32'h00200000)) - 32'sh00100000;
      endcase
   endfunction

   // The valid line drops only on idle cycles, so back-to-back transactions
   // keep it high.
   task automatic send_camera(input logic [31:0] e[3], input logic [31:0] t[3],
                              input logic [31:0] u[3]);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cameras_sent++;
   endtask

   task automatic send_random_camera();
      logic [31:0] e[3], t[3], u[3];
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         e[i] = rand_fix();
         t[i] = rand_fix();
         u[i] = rand_fix();
      end
      // Occasionally force target onto eye, or up parallel to forward or zero.
      if (kind == 0) t = e;
      if (kind == 1) for (int i = 0; i < 3; i++) u[i] = t[i] - e[i];
      if (kind == 2) u = '{0, 0, 0};
      send_camera(e, t, u);
   endtask

   task automatic directed_cameras();
      logic [31:0] e[3], t[3], u[3];
      e = '{0, 0, 32'h00050000};
      t = '{0, 0, 0};
      u = '{0, 32'h00010000, 0};
      send_camera(e, t, u);
      t = e;
      send_camera(e, t, u);
      u = '{0, 0, 0};
      t = '{0, 0, 0};
      send_camera(e, t, u);
      u = '{0, 0, 32'h00010000};
      send_camera(e, t, u);
      e = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      t = '{32'h80000000, 32'h80000000, 32'h80000000};
      u = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
      send_camera(e, t, u);
      send_camera(t, e, u);
      e = '{32'h80000000, 0, 32'h7FFFFFFF};
      t = '{32'h7FFFFFFF, 1, 32'h80000000};
      u = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      send_camera(e, t, u);
      e = '{0, 0, 0};
      t = '{1, 0, 0};
      u = '{0, 1, 0};
      send_camera(e, t, u);
      t = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
      u = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE};
      send_camera(e, t, u);
      e = '{32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F};
      t = '{32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA};
      u = '{32'h00010000, 32'h00010000, 32'h00010000};
      send_camera(e, t, u);
      u = '{32'h80000000, 32'h80000000, 32'h80000000};
      send_camera(e, t, u);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_cameras();
      for (int n = 0; n < FIRST_CAMERAS; n++) send_random_camera();
      // Long receiver stall while the sender keeps pushing; more transactions
      // than there are pipeline stages, so the input stalls.
      sender_idle_pct = 0;
      hold_off <= 400;
      for (int n = 0; n < STALL_CAMERAS; n++) send_random_camera();
      sender_idle_pct = 47;
      receiver_idle_pct = 36;
      for (int n = 0; n < LATE_CAMERAS; n++) send_random_camera();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      for (int n = 0; n < LATE_CAMERAS; n++) send_random_camera();
      req_tvalid <= 0;
      while (pending_columns != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d cameras, %0d matrices checked, %0d flagged degenerate",
               cameras_sent, matrices_seen, degenerate_seen);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILURE");
      end
      $finish;
   end
endmodule
